// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SLSH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("sphere_lambert_shader: assertion failed");

// Clocked assertion that also holds during reset.
`define SLSH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sphere_lambert_shader: assertion failed");

`endif

// ===== hw/rtl/slsh_pkg.sv =====
// Shared constants and helpers for the sphere Lambert shader.
package slsh_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned LevelW = 3;
  localparam int unsigned GlyphW = 7;

  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;

  localparam logic signed [CoordW-1:0] LIGHT_X_RST = 12'sd1008;
  localparam logic signed [CoordW-1:0] LIGHT_Y_RST = 12'sd178;
  localparam logic signed [CoordW-1:0] LIGHT_Z_RST = 12'sd1024;

  localparam logic [GlyphW-1:0] GLYPH_BLANK = 7'd32;
  localparam logic [LevelW-1:0] LEVEL_MAX   = 3'd5;

  // Glyph for a pixel; blank off the disc, ramp ".-+#%@" on it.
  function automatic logic [GlyphW-1:0] glyph_of(input logic on_disc,
                                                 input logic [LevelW-1:0] level);
    logic [GlyphW-1:0] g;
    begin
      case (level)
        3'd0:    g = 7'd46;
        3'd1:    g = 7'd45;
        3'd2:    g = 7'd43;
        3'd3:    g = 7'd35;
        3'd4:    g = 7'd37;
        default: g = 7'd64;
      endcase
      glyph_of = on_disc ? g : GLYPH_BLANK;
    end
  endfunction

endpackage

// ===== hw/rtl/sphere_lambert_shader.sv =====
// Top level of the sphere Lambert shader: stream ports, light registers, pipeline.
// Shades one pixel per clock: a new coordinate pair is taken in every cycle
// while the output side keeps taking results. The pipeline has three input
// stages, one square-root stage per result bit and six shading stages. The
// whole pipeline advances together and holds when a result waits at the
// output. The user must write the light vector through the register port only
// while the pipeline is empty; the block does not enforce it. Only its
// direction matters, and a zero vector shades the disc at level 3.
module sphere_lambert_shader #(
  parameter int unsigned FRAC_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // x_coord [11:0], z_coord [23:12]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // shade_level [2:0], glyph [9:3], zero [15:10]
  output logic        m_axis_tuser_o,   // inside_res [0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned CW = (2 * F + 1 > 24) ? 2 * F + 1 : 24;
  localparam int unsigned NS = F + 1;

  logic en;
  logic signed [slsh_pkg::CoordW-1:0] light_x_q, light_y_q, light_z_q;
  logic [1:0] reg_idx;

  logic                               sv [NS+1];
  logic                               sin [NS+1];
  logic signed [slsh_pkg::CoordW-1:0] sx [NS+1];
  logic signed [slsh_pkg::CoordW-1:0] sz [NS+1];
  logic [23:0]                        sr2 [NS+1];
  logic [CW-1:0]                      srem [NS+1];
  logic [F:0]                         sroot [NS+1];

  logic                               out_v, out_in;
  logic [slsh_pkg::LevelW-1:0]        out_lvl;
  logic [slsh_pkg::GlyphW-1:0]        out_gly;

  assign en              = !out_v || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign reg_idx         = paddr[3:2];
  assign pready          = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= slsh_pkg::LIGHT_X_RST;
      light_y_q <= slsh_pkg::LIGHT_Y_RST;
      light_z_q <= slsh_pkg::LIGHT_Z_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        slsh_pkg::REG_LIGHT_X: light_x_q <= pwdata[11:0];
        slsh_pkg::REG_LIGHT_Y: light_y_q <= pwdata[11:0];
        slsh_pkg::REG_LIGHT_Z: light_z_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      slsh_pkg::REG_LIGHT_X: prdata = 32'(light_x_q);
      slsh_pkg::REG_LIGHT_Y: prdata = 32'(light_y_q);
      slsh_pkg::REG_LIGHT_Z: prdata = 32'(light_z_q);
      default:               prdata = '0;
    endcase
  end

  slsh_front #(.F(F), .CW(CW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .x_i      (s_axis_tdata_i[11:0]),
    .z_i      (s_axis_tdata_i[23:12]),
    .valid_o  (sv[0]),
    .inside_o (sin[0]),
    .x_o      (sx[0]),
    .z_o      (sz[0]),
    .r2_o     (sr2[0]),
    .rem_o    (srem[0])
  );

  assign sroot[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    slsh_sqrt_stage #(.F(F), .CW(CW), .BIT(F - k)) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (sv[k]),
      .inside_i (sin[k]),
      .x_i      (sx[k]),
      .z_i      (sz[k]),
      .r2_i     (sr2[k]),
      .rem_i    (srem[k]),
      .root_i   (sroot[k]),
      .valid_o  (sv[k+1]),
      .inside_o (sin[k+1]),
      .x_o      (sx[k+1]),
      .z_o      (sz[k+1]),
      .r2_o     (sr2[k+1]),
      .rem_o    (srem[k+1]),
      .root_o   (sroot[k+1])
    );
  end

  slsh_shade #(.F(F), .CW(CW)) u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sv[NS]),
    .inside_i (sin[NS]),
    .x_i      (sx[NS]),
    .z_i      (sz[NS]),
    .r2_i     (sr2[NS]),
    .y_i      (sroot[NS]),
    .lx_i     (light_x_q),
    .ly_i     (light_y_q),
    .lz_i     (light_z_q),
    .valid_o  (out_v),
    .inside_o (out_in),
    .level_o  (out_lvl),
    .glyph_o  (out_gly)
  );

  assign m_axis_tvalid_o = out_v;
  assign m_axis_tuser_o  = out_in;
  assign m_axis_tdata_o  = {6'd0, out_gly, out_lvl};

endmodule

// ===== hw/rtl/slsh_front.sv =====
// Input stages: coordinate register, squares, and disc test with radicand.
module slsh_front #(
  parameter int unsigned F  = 10,
  parameter int unsigned CW = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  x_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  z_i,
  output logic                                valid_o,
  output logic                                inside_o,
  output logic signed [slsh_pkg::CoordW-1:0]  x_o,
  output logic signed [slsh_pkg::CoordW-1:0]  z_o,
  output logic [23:0]                         r2_o,
  output logic [CW-1:0]                       rem_o
);

  localparam logic [CW-1:0] OneSq = CW'(1) << (2 * F);

  logic v0_q, v1_q, v2_q;
  logic signed [slsh_pkg::CoordW-1:0] x0_q, z0_q, x1_q, z1_q, x2_q, z2_q;
  logic [23:0] xx_q, zz_q, r2_q;
  logic        inside_q;
  logic [CW-1:0] rem_q;
  logic signed [23:0] xx_d, zz_d;
  logic [CW-1:0] r2_ext;

  assign xx_d   = x0_q * x0_q;
  assign zz_d   = z0_q * z0_q;
  assign r2_ext = CW'(xx_q + zz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q     <= x_i;
      z0_q     <= z_i;
      x1_q     <= x0_q;
      z1_q     <= z0_q;
      xx_q     <= 24'(unsigned'(xx_d));
      zz_q     <= 24'(unsigned'(zz_d));
      x2_q     <= x1_q;
      z2_q     <= z1_q;
      r2_q     <= xx_q + zz_q;
      inside_q <= (r2_ext <= OneSq);
      rem_q    <= (r2_ext <= OneSq) ? (OneSq - r2_ext) : '0;
    end
  end

  assign valid_o  = v2_q;
  assign inside_o = inside_q;
  assign x_o      = x2_q;
  assign z_o      = z2_q;
  assign r2_o     = r2_q;
  assign rem_o    = rem_q;

endmodule

// ===== hw/rtl/slsh_sqrt_stage.sv =====
// One digit of the pipelined integer square root, carrying the pixel along.
module slsh_sqrt_stage #(
  parameter int unsigned F   = 10,
  parameter int unsigned CW  = 24,
  parameter int unsigned BIT = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                inside_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  x_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  z_i,
  input  logic [23:0]                         r2_i,
  input  logic [CW-1:0]                       rem_i,
  input  logic [F:0]                          root_i,
  output logic                                valid_o,
  output logic                                inside_o,
  output logic signed [slsh_pkg::CoordW-1:0]  x_o,
  output logic signed [slsh_pkg::CoordW-1:0]  z_o,
  output logic [23:0]                         r2_o,
  output logic [CW-1:0]                       rem_o,
  output logic [F:0]                          root_o
);

  localparam int unsigned TW = CW + 2;

  logic [TW-1:0] trial, rem_ext;
  logic          take;
  logic          v_q, inside_q;
  logic signed [slsh_pkg::CoordW-1:0] x_q, z_q;
  logic [23:0]   r2_q;
  logic [CW-1:0] rem_q;
  logic [F:0]    root_q;

  // Adding this root bit raises the square by 2*root*2^b + 4^b.
  assign trial   = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign rem_ext = TW'(rem_i);
  assign take    = (rem_ext >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_q <= inside_i;
      x_q      <= x_i;
      z_q      <= z_i;
      r2_q     <= r2_i;
      rem_q    <= take ? CW'(rem_ext - trial) : rem_i;
      root_q   <= take ? (root_i | ((F+1)'(1) << BIT)) : root_i;
    end
  end

  assign valid_o  = v_q;
  assign inside_o = inside_q;
  assign x_o      = x_q;
  assign z_o      = z_q;
  assign r2_o     = r2_q;
  assign rem_o    = rem_q;
  assign root_o   = root_q;

endmodule

// ===== hw/rtl/slsh_shade.sv =====
// Back end: dot product, squared norms, exact threshold compare, output register.
module slsh_shade #(
  parameter int unsigned F  = 10,
  parameter int unsigned CW = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                inside_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  x_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  z_i,
  input  logic [23:0]                         r2_i,
  input  logic [F:0]                          y_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  lx_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  ly_i,
  input  logic signed [slsh_pkg::CoordW-1:0]  lz_i,
  output logic                                valid_o,
  output logic                                inside_o,
  output logic [slsh_pkg::LevelW-1:0]         level_o,
  output logic [slsh_pkg::GlyphW-1:0]         glyph_o
);

  localparam int unsigned PYW = F + 14;
  localparam int unsigned DW  = ((PYW > 24) ? PYW : 24) + 2;
  localparam int unsigned AH  = DW - 16;
  localparam int unsigned A2W = 2 * DW;
  localparam int unsigned NW  = CW + 1;
  localparam int unsigned NH  = NW - 16;
  localparam int unsigned LW  = 25;
  localparam int unsigned MW  = NW + LW;
  localparam int unsigned QW  = A2W + 4;
  localparam int unsigned KW  = (QW > MW + 2) ? QW : MW + 2;

  // Stage A: products.
  logic               va_q, ina_q;
  logic signed [23:0] px_q, pz_q, lxx_q, lyy_q, lzz_q;
  logic signed [PYW-1:0] py_q;
  logic [2*F+1:0]     yy_q;
  logic [23:0]        r2a_q;
  logic signed [PYW-1:0] py_d;
  // Stage B: sums.
  logic               vb_q, inb_q;
  logic signed [DW-1:0] d_q;
  logic [NW-1:0]      nn_q;
  logic [LW-1:0]      ll_q;
  // Stage C: partial products of the wide squares.
  logic               vc_q, inc_q, dpos_c_q, dneg_c_q;
  logic [DW-1:0]      ad_c;
  logic [2*AH-1:0]    ahh_q;
  logic [AH+15:0]     ahl_q;
  logic [31:0]        all_q;
  logic [NH+LW-1:0]   mh_q;
  logic [16+LW-1:0]   ml_q;
  // Stage D: recombined squares.
  logic               vd_q, ind_q, dpos_d_q, dneg_d_q;
  logic [A2W-1:0]     ad2_q;
  logic [MW-1:0]      mm_q;
  // Stage E: nine times the dot square.
  logic               ve_q, ine_q, dpos_e_q, dneg_e_q;
  logic [KW-1:0]      q_q, mm_e_q;
  // Output register.
  logic               vo_q, ino_q;
  logic [slsh_pkg::LevelW-1:0] lvl_q;
  logic [slsh_pkg::GlyphW-1:0] gly_q;
  logic [KW-1:0]      mm4;
  logic [2:0]         cnt;
  logic [slsh_pkg::LevelW-1:0] lvl_d;

  assign py_d = ly_i * $signed({1'b0, y_i});
  assign ad_c = d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
  assign mm4  = mm_e_q << 2;

  // Level counts the thresholds -2/3..2/3 that the cosine reaches.
  always_comb begin
    cnt = 3'd0;
    if (dpos_e_q || (!dneg_e_q) || (q_q <= mm4))   cnt = cnt + 3'd1;
    if (dpos_e_q || (!dneg_e_q) || (q_q <= mm_e_q)) cnt = cnt + 3'd1;
    if (!dneg_e_q)                                  cnt = cnt + 3'd1;
    if (dpos_e_q && (q_q >= mm_e_q))                cnt = cnt + 3'd1;
    if (dpos_e_q && (q_q >= mm4))                   cnt = cnt + 3'd1;
    lvl_d = (cnt > slsh_pkg::LEVEL_MAX) ? slsh_pkg::LEVEL_MAX : cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vo_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ina_q    <= inside_i;
      px_q     <= lx_i * x_i;
      py_q     <= py_d;
      pz_q     <= lz_i * z_i;
      yy_q     <= (2*F+2)'(y_i) * (2*F+2)'(y_i);
      lxx_q    <= lx_i * lx_i;
      lyy_q    <= ly_i * ly_i;
      lzz_q    <= lz_i * lz_i;
      r2a_q    <= r2_i;

      inb_q    <= ina_q;
      d_q      <= DW'(px_q) + DW'(py_q) + DW'(pz_q);
      nn_q     <= NW'(r2a_q) + NW'(yy_q);
      ll_q     <= LW'(unsigned'(lxx_q)) + LW'(unsigned'(lyy_q)) + LW'(unsigned'(lzz_q));

      inc_q    <= inb_q;
      dpos_c_q <= (!d_q[DW-1]) && (d_q != '0);
      dneg_c_q <= d_q[DW-1];
      ahh_q    <= ad_c[DW-1:16] * ad_c[DW-1:16];
      ahl_q    <= ad_c[DW-1:16] * ad_c[15:0];
      all_q    <= ad_c[15:0] * ad_c[15:0];
      mh_q     <= nn_q[NW-1:16] * ll_q;
      ml_q     <= nn_q[15:0] * ll_q;

      ind_q    <= inc_q;
      dpos_d_q <= dpos_c_q;
      dneg_d_q <= dneg_c_q;
      ad2_q    <= (A2W'(ahh_q) << 32) + (A2W'(ahl_q) << 17) + A2W'(all_q);
      mm_q     <= (MW'(mh_q) << 16) + MW'(ml_q);

      ine_q    <= ind_q;
      dpos_e_q <= dpos_d_q;
      dneg_e_q <= dneg_d_q;
      q_q      <= (KW'(ad2_q) << 3) + KW'(ad2_q);
      mm_e_q   <= KW'(mm_q);

      ino_q    <= ine_q;
      lvl_q    <= ine_q ? lvl_d : '0;
      gly_q    <= slsh_pkg::glyph_of(ine_q, lvl_d);
    end
  end

  assign valid_o  = vo_q;
  assign inside_o = ino_q;
  assign level_o  = lvl_q;
  assign glyph_o  = gly_q;

endmodule

// ===== hw/rtl/slsh_checker.sv =====
// Port-level checks for the sphere Lambert shader, bound to the top level.
`include "assert_macros.svh"

module slsh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        pready
);

  logic [slsh_pkg::LevelW-1:0] out_level;
  logic [slsh_pkg::GlyphW-1:0] out_glyph;
  logic [16:0]                 out_bits;
  logic                        level_ok, glyph_ok, out_stall;

  assign out_level = m_axis_tdata_o[2:0];
  assign out_glyph = m_axis_tdata_o[9:3];
  assign out_bits  = {m_axis_tuser_o, m_axis_tdata_o};
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign level_ok  = m_axis_tuser_o ? (out_level <= slsh_pkg::LEVEL_MAX) : (out_level == '0);
  assign glyph_ok  = (out_glyph == slsh_pkg::glyph_of(m_axis_tuser_o, out_level));

  // An empty output register never blocks the input side.
  `SLSH_ASSERT(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o)
  // A pixel off the disc has level zero; on it the level stays within range.
  `SLSH_ASSERT(a_level_range, clk_i, rst_ni, m_axis_tvalid_o |-> level_ok)
  // The glyph always follows from the level and the disc flag.
  `SLSH_ASSERT(a_glyph_match, clk_i, rst_ni, m_axis_tvalid_o |-> glyph_ok)
  // A stalled result holds.
  `SLSH_ASSERT(a_stall_hold, clk_i, rst_ni, out_stall |=> (m_axis_tvalid_o && $stable(out_bits)))
  `SLSH_ASSERT_ALWAYS(a_pready_high, clk_i, pready)

endmodule

bind sphere_lambert_shader slsh_checker u_slsh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .pready          (pready)
);

// ===== bench/sphere_lambert_shader_test.sv =====
// Self-checking bench for the sphere Lambert shader: stream traffic, register writes, scoreboard.
module sphere_lambert_shader_test;

  localparam int Latency = 20;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic                          on_disc;
    logic [slsh_pkg::LevelW-1:0]   level;
    logic [slsh_pkg::GlyphW-1:0]   glyph;
  } pixel_t;

  class shade_board;
    logic signed [slsh_pkg::CoordW-1:0] lx, ly, lz;
    pixel_t pending[$];
    int errors;
    int checked;

    function new();
      lx = slsh_pkg::LIGHT_X_RST;
      ly = slsh_pkg::LIGHT_Y_RST;
      lz = slsh_pkg::LIGHT_Z_RST;
      errors = 0;
      checked = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Works out the shade of one pixel and queues it.
    function void note_pixel(logic [11:0] xr, logic [11:0] zr);
      longint x, z, one, r2, y, d, m;
      longint unsigned ad, q, nn, ll, mm;
      int lvl;
      pixel_t p;
      x = longint'($signed(xr));
      z = longint'($signed(zr));
      one = 1024;
      r2 = x * x + z * z;
      if (r2 > one * one) begin
        p = '{1'b0, 3'd0, slsh_pkg::GLYPH_BLANK};
      end else begin
        y = longint'(int_sqrt(longint'(one * one - r2)));
        d = longint'(lx) * x + longint'(ly) * y + longint'(lz) * z;
        ad = (d < 0) ? -d : d;
        q = 9 * ad * ad;
        nn = r2 + y * y;
        ll = longint'(lx) * lx + longint'(ly) * ly + longint'(lz) * lz;
        mm = nn * ll;
        lvl = 0;
        for (m = -2; m <= 2; m++) begin
          if (m == 0) lvl += (d >= 0);
          else if (m > 0) lvl += (d > 0) && (q >= longint'(m * m) * mm);
          else lvl += (d >= 0) || (q <= longint'(m * m) * mm);
        end
        if (lvl > 5) lvl = 5;
        p.on_disc = 1'b1;
        p.level = 3'(lvl);
        p.glyph = slsh_pkg::glyph_of(1'b1, 3'(lvl));
      end
      pending.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_p;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_p = pending.pop_front();
      checked++;
      if (got.on_disc !== exp_p.on_disc) begin
        $display("%0t: inside_res expected %0d actual %0d", $time, exp_p.on_disc, got.on_disc);
        errors++;
      end
      if (got.level !== exp_p.level) begin
        $display("%0t: shade_level expected %0d actual %0d", $time, exp_p.level, got.level);
        errors++;
      end
      if (got.glyph !== exp_p.glyph) begin
        $display("%0t: glyph expected %0d actual %0d", $time, exp_p.glyph, got.glyph);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  sphere_lambert_shader dut (.*);

  shade_board board = new();
  int send_idle_pct, recv_idle_pct;
  int hold_cycles;
  int quiet = 0;
  int pixels_sent;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stalls plus an optional long hold-off.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_pixel({m_axis_tuser_o, m_axis_tdata_o[2:0], m_axis_tdata_o[9:3]});
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one pixel; tvalid stays high afterwards so pixels can follow back to back.
  task automatic send_pixel(logic [11:0] x, logic [11:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {z, x};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_pixel(x, z);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_light(logic [1:0] idx, logic [11:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{20{val[11]}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      slsh_pkg::REG_LIGHT_X: board.lx = val;
      slsh_pkg::REG_LIGHT_Y: board.ly = val;
      slsh_pkg::REG_LIGHT_Z: board.lz = val;
      default: ;
    endcase
  endtask

  task automatic set_light(logic [11:0] x, logic [11:0] y, logic [11:0] z);
    drain();
    write_light(slsh_pkg::REG_LIGHT_X, x);
    write_light(slsh_pkg::REG_LIGHT_Y, y);
    write_light(slsh_pkg::REG_LIGHT_Z, z);
  endtask

  // Mostly points on or near the disc, some anywhere in the 12-bit range.
  task automatic random_pixels(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(1100, 0);
      if ($urandom_range(9) < 2)
        send_pixel(12'($urandom), 12'($urandom));
      else
        send_pixel(12'(int'($urandom_range(2 * r)) - r),
                   12'(int'($urandom_range(2 * r)) - r));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_cycles = 0;
    pixels_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: center, edge of disc, extremes of range, just off the edge.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1024, 12'd0);
    send_pixel(-12'sd1024, 12'd0);
    send_pixel(12'd0, 12'd1024);
    send_pixel(12'd0, -12'sd1024);
    send_pixel(12'd1025, 12'd0);
    send_pixel(12'h7FF, 12'h7FF);
    send_pixel(12'h800, 12'h800);
    send_pixel(12'h800, 12'h7FF);
    send_pixel(12'd614, 12'd819);
    send_pixel(12'd724, 12'd724);
    send_pixel(12'hFFF, 12'hFFF);
    // Light straight overhead: the center hits full brightness exactly.
    set_light(12'd0, 12'd1024, 12'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1024, 12'd0);
    // Zero light vector shades the whole disc at level 3.
    set_light(12'd0, 12'd0, 12'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd300, -12'sd500);
    send_pixel(12'd1500, 12'd0);
    set_light(12'h7FF, 12'h800, 12'h7FF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1024, 12'd0);
    send_pixel(-12'sd1024, 12'd0);
    set_light(slsh_pkg::LIGHT_X_RST, slsh_pkg::LIGHT_Y_RST, slsh_pkg::LIGHT_Z_RST);

    send_idle_pct = 16;
    recv_idle_pct = 63;
    random_pixels(400);
    set_light(12'($urandom), 12'($urandom), 12'($urandom));
    send_idle_pct = 63;
    recv_idle_pct = 16;
    random_pixels(400);
    set_light(12'($urandom), 12'($urandom), 12'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long receiver hold-off while the sender keeps offering pixels.
    hold_cycles = 200;
    random_pixels(100);
    drain();
    set_light(12'h800, 12'h800, 12'h800);
    random_pixels(300);

    drain();
    $display("Shaded %0d pixels, %0d results checked, across several light settings",
             pixels_sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/slsh_pkg.sv
hw/rtl/slsh_front.sv
hw/rtl/slsh_sqrt_stage.sv
hw/rtl/slsh_shade.sv
hw/rtl/sphere_lambert_shader.sv
hw/rtl/slsh_checker.sv
bench/sphere_lambert_shader_test.sv
